/* rtl/core/bth_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_pkg
// Shared types, constants and helpers for the tile halving downsampler.
// ----------------------------------------------------------------------------
package bth_pkg;

  // Geometry
  localparam int TILE_SIDE = 64;
  localparam int HALF      = TILE_SIDE / 2;
  localparam int PART_W    = 2 * HALF;
  localparam int DATA_W    = 64;
  localparam int NUM_W     = 6;
  localparam int CLASS_W   = 2;
  localparam int POS_W     = $clog2(4 * TILE_SIDE);
  localparam int ROW_W     = POS_W - 2;

  // Queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  // Quadrant and tile class codes
  typedef enum logic [CLASS_W-1:0] {
    CLS_FREE    = 2'd0,
    CLS_BLOCKED = 2'd1,
    CLS_MIXED   = 2'd2
  } class_t;

  // One classified quadrant row
  typedef struct packed {
    logic [HALF-1:0] bits;
    logic            right;
    logic            mark_free;
    logic            mark_blocked;
  } entry_t;

  // OR adjacent pixel pairs of one quadrant row
  function automatic logic [HALF-1:0] halve_row(input logic [PART_W-1:0] v);
    logic [HALF-1:0] r;
    for (int n = 0; n < HALF; n++) begin
      r[n] = v[2*n] | v[2*n+1];
    end
    return r;
  endfunction

endpackage

/* rtl/core/bth_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_in_if / bth_out_if
// Valid/ready channels for quadrant rows in and halved rows out.
// ----------------------------------------------------------------------------
interface bth_in_if;
  logic                         valid;
  logic                         ready;
  logic [bth_pkg::CLASS_W-1:0]  quadrant_class;
  logic [bth_pkg::DATA_W-1:0]   source_row;

  modport source (output valid, quadrant_class, source_row, input ready);
  modport sink   (input valid, quadrant_class, source_row, output ready);
endinterface

interface bth_out_if;
  logic                         valid;
  logic                         ready;
  logic [bth_pkg::DATA_W-1:0]   halved_row;
  logic [bth_pkg::NUM_W-1:0]    row_number;
  logic [bth_pkg::CLASS_W-1:0]  tile_class;
  logic                         last_row;

  modport source (output valid, halved_row, row_number, tile_class, last_row,
                  input ready);
  modport sink   (input valid, halved_row, row_number, tile_class, last_row,
                  output ready);
endinterface

/* rtl/core/bth_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_front
// Accepts quadrant rows, halves them and sets the class marks.
// ----------------------------------------------------------------------------
module bth_front (
  input  logic            clk,
  input  logic            rst_n,
  bth_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output bth_pkg::entry_t push_data
);
  import bth_pkg::*;

  logic              right_r;
  logic              right_nxt;
  logic [PART_W-1:0] used_bits;
  logic              accept;

  assign in_ch.ready = push_ready;
  assign push_valid  = in_ch.valid;
  assign accept      = in_ch.valid & push_ready;
  assign used_bits   = in_ch.source_row[PART_W-1:0];

  // Classify the row and build its contribution
  always_comb begin
    push_data.right = right_r;
    case (in_ch.quadrant_class)
      CLS_FREE: begin
        push_data.bits         = '0;
        push_data.mark_free    = 1'b1;
        push_data.mark_blocked = 1'b0;
      end
      CLS_BLOCKED: begin
        push_data.bits         = '1;
        push_data.mark_free    = 1'b0;
        push_data.mark_blocked = 1'b1;
      end
      default: begin
        // mixed, and the unused code treated as mixed
        push_data.bits         = halve_row(used_bits);
        push_data.mark_free    = ~&used_bits;
        push_data.mark_blocked = |used_bits;
      end
    endcase
  end

  // Alternate left and right quadrant on each transaction
  assign right_nxt = accept ? ~right_r : right_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      right_r <= 1'b0;
    end else begin
      right_r <= right_nxt;
    end
  end

endmodule

/* rtl/core/bth_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module bth_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  bth_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bth_pkg::entry_t pop_data
);
  import bth_pkg::*;

  entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue occupancy above depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push without pop did not grow the queue");
`endif

endmodule

/* rtl/core/bth_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bth_back
// Merges four classified rows into one halved row and tracks the tile class.
// ----------------------------------------------------------------------------
module bth_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  bth_pkg::entry_t pop_data,
  bth_out_if.source       out_ch
);
  import bth_pkg::*;

  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [PART_W-1:0]  partial_r, partial_nxt;
  logic               saw_free_r, saw_free_nxt;
  logic               saw_blocked_r, saw_blocked_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PART_W-1:0]  out_row_r;
  logic [ROW_W-1:0]   out_num_r;
  class_t             out_class_r;
  logic               out_last_r;

  logic [PART_W-1:0]  contrib;
  logic [PART_W-1:0]  merged;
  logic [ROW_W-1:0]   row;
  logic               completes, last, take;
  logic               free_all, blocked_all;
  class_t             tile_cls;

  assign completes = (pos_r[1:0] == 2'b11);
  assign row       = pos_r[POS_W-1:2];
  assign last      = (row == ROW_W'(TILE_SIDE - 1));
  assign pop_ready = ~completes | ~out_valid_r | out_ch.ready;
  assign take      = pop_valid & pop_ready;

  // Place the contribution in its half and merge
  assign contrib = pop_data.right ? {pop_data.bits, {HALF{1'b0}}}
                                  : {{HALF{1'b0}}, pop_data.bits};
  assign merged      = partial_r | contrib;
  assign free_all    = saw_free_r | pop_data.mark_free;
  assign blocked_all = saw_blocked_r | pop_data.mark_blocked;

  // Resolve the tile class from the marks
  always_comb begin
    case ({free_all, blocked_all})
      2'b11:   tile_cls = CLS_MIXED;
      2'b10:   tile_cls = CLS_FREE;
      default: tile_cls = CLS_BLOCKED;
    endcase
  end

  // Advance accumulation state
  always_comb begin
    pos_nxt         = pos_r;
    partial_nxt     = partial_r;
    saw_free_nxt    = saw_free_r;
    saw_blocked_nxt = saw_blocked_r;
    out_valid_nxt   = out_valid_r & ~out_ch.ready;
    if (take) begin
      saw_free_nxt    = free_all;
      saw_blocked_nxt = blocked_all;
      partial_nxt     = merged;
      pos_nxt         = pos_r + 1'b1;
      if (completes) begin
        partial_nxt   = '0;
        out_valid_nxt = 1'b1;
        if (last) begin
          pos_nxt         = '0;
          saw_free_nxt    = 1'b0;
          saw_blocked_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      partial_r     <= '0;
      saw_free_r    <= 1'b0;
      saw_blocked_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      partial_r     <= partial_nxt;
      saw_free_r    <= saw_free_nxt;
      saw_blocked_r <= saw_blocked_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Load the output register on a finished row
  always_ff @(posedge clk) begin
    if (take && completes) begin
      out_row_r   <= merged;
      out_num_r   <= row;
      out_last_r  <= last;
      out_class_r <= last ? tile_cls : CLS_FREE;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.halved_row = DATA_W'(out_row_r);
  assign out_ch.row_number = NUM_W'(out_num_r);
  assign out_ch.tile_class = out_class_r;
  assign out_ch.last_row   = out_last_r;

`ifndef NO_ASSERTIONS
  a_last_number: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_num_r == ROW_W'(TILE_SIDE - 1)))
    else $error("last row flagged on wrong row number");

  a_class_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (out_class_r == CLS_FREE))
    else $error("tile class set on a row that is not last");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !(take && completes))
    else $error("finished row overwrote a pending result");

  a_marks_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (take && completes && last) |=> (!saw_free_r && !saw_blocked_r && pos_r == '0))
    else $error("tile state not cleared after last row");
`endif

endmodule

/* rtl/core/binary_tile_halving_downsampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_tile_halving_downsampler
// Halves a 2x2 group of blocked/free bitmap tiles into one tile, row by row.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                          | handshake
//  in_ch    | in  | quadrant_class[1:0], source_row[63:0]            | valid/ready
//  out_ch   | out | halved_row[63:0], row_number[5:0], tile_class,   | valid/ready
//           |     | last_row                                         |
//
//  One quadrant row is taken per cycle unless the queue is full; a result
//  appears after every fourth. A transaction passes the front in its accept
//  cycle, is registered in the two-entry queue, and the merged row is then
//  registered in the output stage, which drives out_ch.valid.
//  Synchronous active-low reset clears the queue, counters and class marks.
//  A stalled output blocks only the row that completes a result; the queue
//  absorbs short stalls before in_ch.ready drops.
// ----------------------------------------------------------------------------
module binary_tile_halving_downsampler (
  input  logic      clk,
  input  logic      rst_n,
  bth_in_if.sink    in_ch,
  bth_out_if.source out_ch
);
  import bth_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   pop_valid, pop_ready;
  entry_t pop_data;

  bth_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  bth_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bth_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule
